// ===== hdl/rops_pkg.sv =====
// Shared types, constants and the entry compare for the render order sorter.
`default_nettype none

package rops_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  typedef struct packed {
    logic [15:0]        handle;
    logic [15:0]        layer;
    logic signed [23:0] y_pos;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        out_handle;
    logic [15:0]        out_layer;
    logic signed [23:0] out_y_pos;
    logic               out_last;
  } out_word_t;

  // one stored list entry
  typedef struct packed {
    logic [15:0]        handle;
    logic [15:0]        layer;
    logic signed [23:0] y_pos;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_F_PRIME,
    ST_F_HEAD,
    ST_F_RUN,
    ST_F_TAIL,
    ST_B_RUN,
    ST_B_TAIL,
    ST_EMIT
  } state_t;

  // sequencer to compare unit
  typedef struct packed {
    logic load;      // carry takes the read word
    logic step;      // one compare and exchange step
    logic bwd;       // backward pass
    logic clr_swap;  // start of a forward pass
  } swap_ctl_t;

  // true when a must come after b: layer first, then signed position
  function automatic logic entry_greater(input entry_t a, input entry_t b);
    logic gt;
    if (a.layer != b.layer) begin
      gt = (a.layer > b.layer);
    end else begin
      gt = (a.y_pos > b.y_pos);
    end
    return gt;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/render_order_partial_sort_top.sv =====
// Render order partial sort: collects a list, runs one cocktail shaker pass, emits it.
// A list of n entries is loaded at one word per cycle until last is seen or the store
// (MAX_ENTRIES deep) fills. In render mode a list of two or more entries then gets a
// forward bubble pass and, only if that pass exchanged anything, a backward pass;
// one compare unit and the single write port of the entry store do one neighbour pair
// per cycle. The list is then read out at one word per cycle while the output is not
// stalled, set by the store's read port. Input is stalled from the end of a list until
// its last word has been read out; that last word may still wait at the output while
// the next list loads.
// Ordering is by layer (unsigned), then y_pos (signed); equal keys keep their order.
`default_nettype none

module render_order_partial_sort_top
  import rops_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          render_mode_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;

  entry_t        mem_r [MAX_ENTRIES];
  entry_t        rd_data_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data;

  swap_ctl_t     swap_ctl;
  entry_t        wr_entry, carry;
  logic          swap_seen;

  logic          in_acc, cfg_wr, out_free;
  logic [CW-1:0] count_inc, cnt_m1, cnt_m2, idx_inc, idx_dec, idx_dec2;
  logic          load_end, at_last, idx_one;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, render_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      render_mode_r <= 1'b1;
    end else if (cfg_wr && !paddr[2]) begin
      render_mode_r <= pwdata[0];
    end
  end

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign count_inc = count_r + 1'b1;
  assign cnt_m1    = count_r - 1'b1;
  assign cnt_m2    = count_r - 2'd2;
  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign idx_dec2  = idx_r - 2'd2;
  assign load_end  = in_word.last || (count_inc == CW'(MAX_ENTRIES));
  assign at_last   = (idx_r == cnt_m1);
  assign idx_one   = (idx_r == CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && load_end) begin
          state_nxt = (render_mode_r && count_inc >= CW'(2)) ? ST_F_PRIME : ST_EMIT;
        end
      end
      ST_F_PRIME: if (!out_valid_r) state_nxt = ST_F_HEAD;
      ST_F_HEAD:  state_nxt = ST_F_RUN;
      ST_F_RUN:   if (at_last) state_nxt = ST_F_TAIL;
      ST_F_TAIL:  state_nxt = swap_seen ? ST_B_RUN : ST_EMIT;
      ST_B_RUN:   if (idx_one) state_nxt = ST_B_TAIL;
      ST_B_TAIL:  state_nxt = ST_EMIT;
      ST_EMIT:    if (out_free && at_last) state_nxt = ST_LOAD;
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // sequencer outputs and datapath control
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = carry;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    swap_ctl      = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          wr_en     = 1'b1;
          wr_addr   = count_r[AW-1:0];
          wr_data   = '{handle: in_word.handle, layer: in_word.layer, y_pos: in_word.y_pos};
          count_nxt = count_inc;
          idx_nxt   = '0;
        end
      end
      ST_F_PRIME: begin
        if (!out_valid_r) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      ST_F_HEAD: begin
        swap_ctl.load     = 1'b1;
        swap_ctl.clr_swap = 1'b1;
        rd_en             = 1'b1;
        rd_addr           = AW'(1);
        idx_nxt           = CW'(1);
      end
      ST_F_RUN: begin
        swap_ctl.step = 1'b1;
        wr_en         = 1'b1;
        wr_addr       = idx_dec[AW-1:0];
        wr_data       = wr_entry;
        if (!at_last) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
          idx_nxt = idx_inc;
        end
      end
      ST_F_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m1[AW-1:0];
        wr_data = carry;
        if (swap_seen) begin
          // the word at n-2 was written last cycle, so this read sees it
          rd_en   = 1'b1;
          rd_addr = cnt_m2[AW-1:0];
          idx_nxt = cnt_m1;
        end else begin
          idx_nxt = '0;
        end
      end
      ST_B_RUN: begin
        swap_ctl.step = 1'b1;
        swap_ctl.bwd  = 1'b1;
        wr_en         = 1'b1;
        wr_addr       = idx_r[AW-1:0];
        wr_data       = wr_entry;
        if (!idx_one) begin
          rd_en   = 1'b1;
          rd_addr = idx_dec2[AW-1:0];
          idx_nxt = idx_dec;
        end
      end
      ST_B_TAIL: begin
        swap_ctl.bwd = 1'b1;
        wr_en        = 1'b1;
        wr_addr      = '0;
        wr_data      = carry;
        idx_nxt      = '0;
      end
      ST_EMIT: begin
        // the read register doubles as the output word register
        if (out_free) begin
          rd_en         = 1'b1;
          rd_addr       = idx_r[AW-1:0];
          out_valid_nxt = 1'b1;
          out_last_nxt  = at_last;
          idx_nxt       = idx_inc;
          if (at_last) begin
            count_nxt = '0;
            idx_nxt   = '0;
          end
        end
      end
      default: begin
        count_nxt = '0;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  rops_swap_unit u_swap (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (swap_ctl),
    .rd_entry  (rd_data_r),
    .wr_entry  (wr_entry),
    .carry     (carry),
    .swap_seen (swap_seen)
  );

  assign out_valid = out_valid_r;
  assign out_word  = '{out_handle: rd_data_r.handle, out_layer: rd_data_r.layer,
                       out_y_pos: rd_data_r.y_pos, out_last: out_last_r};

  // a sort read must not clobber a word still waiting at the output
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && (state_r != ST_EMIT) |-> !out_valid_r)
    else $error("read register overwritten while output word pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write at the same store address");

  a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("output word raised outside read-out");

  a_back_needs_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F_TAIL) && (state_nxt == ST_B_RUN) |-> swap_seen)
    else $error("backward pass without forward exchange");

endmodule

`default_nettype wire

// ===== hdl/rops_swap_unit.sv =====
// Shared compare and exchange unit: holds the bubbling entry and the swap flag.
`default_nettype none

module rops_swap_unit
  import rops_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire swap_ctl_t ctl,
  input  wire entry_t    rd_entry,
  output entry_t         wr_entry,
  output entry_t         carry,
  output logic           swap_seen
);

  entry_t carry_r;
  logic   swap_seen_r;
  logic   swap;

  // forward pass carries the larger entry up, backward pass the smaller one down
  always_comb begin
    swap     = ctl.bwd ? entry_greater(rd_entry, carry_r) : entry_greater(carry_r, rd_entry);
    wr_entry = swap ? rd_entry : carry_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      carry_r <= rd_entry;
    end else if (ctl.step && !swap) begin
      carry_r <= rd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_seen_r <= 1'b0;
    end else if (ctl.clr_swap) begin
      swap_seen_r <= 1'b0;
    end else if (ctl.step && !ctl.bwd && swap) begin
      swap_seen_r <= 1'b1;
    end
  end

  assign carry     = carry_r;
  assign swap_seen = swap_seen_r;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the render order partial sort: directed lists, then random ones.
module tb_top;
  import rops_pkg::*;

  localparam int unsigned LIST_MAX        = MAX_ENTRIES_DEF;
  localparam int unsigned REG_RENDER_MODE = 0;
  localparam int unsigned REG_SPARE       = 1;  // no register behind it; writes are ignored
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned PHASE_WORDS     = 33;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned REPORT_MAX      = 10;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_mode_t;
  typedef enum logic [1:0] {KEYS_WIDE, KEYS_CLUSTERED, KEYS_ONE_LAYER, KEYS_DESCENDING} keys_t;

  typedef struct packed {
    row_kind_t   kind;
    in_word_t    word;
    logic        typed;
    out_word_t   want;
    logic [2:0]  idx;
    logic [31:0] data;
  } dir_row_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_word_t    in_word;
  out_word_t   out_word;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  render_order_partial_sort_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---- predictor: list store, sort switch and the words due out, oldest first
  entry_t      list_store [LIST_MAX];
  int unsigned list_len;
  logic        sort_on;
  out_word_t   list_out[$];
  out_word_t   typed_q[$];
  out_word_t   order_q[$];
  int unsigned bad_words;
  int unsigned burst_left;
  dir_row_t    dir_tab[$];

  // layer, then position; flipping the sign bit turns the signed compare into an unsigned one
  function automatic logic goes_after(entry_t a, entry_t b);
    return {a.layer, ~a.y_pos[23], a.y_pos[22:0]} > {b.layer, ~b.y_pos[23], b.y_pos[22:0]};
  endfunction

  function automatic logic swap_pair(int i);
    entry_t t;
    if (!goes_after(list_store[i-1], list_store[i])) return 1'b0;
    t = list_store[i-1];
    list_store[i-1] = list_store[i];
    list_store[i] = t;
    return 1'b1;
  endfunction

  function automatic void take_entry(in_word_t w);
    int  n;
    int  i;
    logic moved;
    out_word_t o;
    list_store[list_len] = '{handle: w.handle, layer: w.layer, y_pos: w.y_pos};
    list_len++;
    if (!w.last && list_len < LIST_MAX) return;
    n = list_len;
    if (sort_on && n >= 2) begin
      moved = 1'b0;
      for (i = 1; i < n; i++) if (swap_pair(i)) moved = 1'b1;
      // the backward pass only runs when the forward one changed something
      if (moved) for (i = n - 1; i >= 1; i--) void'(swap_pair(i));
    end
    for (i = 0; i < n; i++) begin
      o.out_handle = list_store[i].handle;
      o.out_layer  = list_store[i].layer;
      o.out_y_pos  = list_store[i].y_pos;
      o.out_last   = (i == n - 1);
      list_out.push_back(o);
    end
    list_len = 0;
  endfunction

  function automatic void note_bad(string what, out_word_t want, out_word_t got);
    bad_words++;
    if (bad_words <= REPORT_MAX)
      $display("%s: want h=%h l=%h y=%h last=%b, got h=%h l=%h y=%h last=%b", what,
               want.out_handle, want.out_layer, want.out_y_pos, want.out_last,
               got.out_handle, got.out_layer, got.out_y_pos, got.out_last);
  endfunction

  function automatic in_word_t mk_word(logic [15:0] h, logic [15:0] l, logic [23:0] y,
                                       logic last);
    in_word_t w;
    w.handle = h;
    w.layer  = l;
    w.y_pos  = y;
    w.last   = last;
    return w;
  endfunction

  function automatic dir_row_t word_row(logic [15:0] h, logic [15:0] l, logic [23:0] y,
                                        logic last);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.word = mk_word(h, l, y, last);
    return r;
  endfunction

  // word whose output at the same list position is known outright
  function automatic dir_row_t typed_row(logic [15:0] h, logic [15:0] l, logic [23:0] y,
                                         logic last, logic [15:0] wh, logic [15:0] wl,
                                         logic [23:0] wy);
    dir_row_t r;
    r = word_row(h, l, y, last);
    r.typed = 1'b1;
    r.want  = {wh, wl, wy, last};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(int unsigned idx, logic [31:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = 3'(idx);
    r.data = data;
    return r;
  endfunction

  // ---- input side
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (typed) typed_q.push_back(want);
    take_entry(w);
    if (list_out.size() != 0) begin
      if (typed_q.size() != 0) foreach (typed_q[i]) order_q.push_back(typed_q[i]);
      else foreach (list_out[i]) order_q.push_back(list_out[i]);
      typed_q.delete();
      list_out.delete();
    end
  endtask

  task automatic send_list(int unsigned n, logic close);
    keys_t       keys;
    logic [15:0] one_layer;
    logic [15:0] l;
    logic [23:0] y;
    int          tmp;
    keys = keys_t'($urandom_range(0, 3));
    one_layer = 16'($urandom);
    for (int unsigned k = 0; k < n; k++) begin
      tmp = $urandom_range(0, 6);
      case (keys)
        KEYS_WIDE: begin
          l = 16'($urandom);
          y = 24'($urandom);
        end
        KEYS_CLUSTERED: begin
          l = 16'($urandom_range(0, 3));
          y = 24'(tmp - 3);
        end
        KEYS_ONE_LAYER: begin
          l = one_layer;
          y = 24'($urandom);
        end
        default: begin
          l = 16'(n - k);
          y = 24'(tmp - 3);
        end
      endcase
      pace_sender();
      send_word(mk_word(16'($urandom), l, y, close && k == n - 1), 1'b0, '0);
    end
  endtask

  // ---- configuration port
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(int unsigned idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_RENDER_MODE) sort_on = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_check_mode();
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(4 * REG_RENDER_MODE);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== {31'b0, sort_on}) begin
      bad_words++;
      if (bad_words <= REPORT_MAX)
        $display("render_mode read: want %h, got %h", {31'b0, sort_on}, got);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---- result side
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (order_q.size() == 0) begin
        note_bad("unexpected word", '0, out_word);
      end else begin
        want = order_q.pop_front();
        if (out_word.out_handle !== want.out_handle || out_word.out_layer !== want.out_layer ||
            out_word.out_y_pos !== want.out_y_pos || out_word.out_last !== want.out_last)
          note_bad("word mismatch", want, out_word);
      end
    end
  end

  // receiver stalls in modes chosen at random, each held for a random span
  initial begin
    stall_mode_t mode;
    int unsigned left;
    int unsigned tick;
    out_stall = 1'b0;
    left = 0;
    tick = 0;
    mode = STALL_NONE;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 80);
      end
      left--;
      tick++;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_RUNS:  out_stall <= ((tick % 7) < 3);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog on cycles where no word moves on any port
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("** render_order_partial_sort_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    logic [31:0] data;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    list_len   = 0;
    sort_on    = 1'b1;
    bad_words  = 0;
    burst_left = 0;

    // one entry, all fields at their top
    dir_tab.push_back(typed_row(16'hFFFF, 16'hFFFF, 24'h7FFFFF, 1'b1,
                                16'hFFFF, 16'hFFFF, 24'h7FFFFF));
    // layer decides
    dir_tab.push_back(typed_row(16'h0001, 16'hFFFF, 24'h000000, 1'b0,
                                16'h0002, 16'h0000, 24'h000000));
    dir_tab.push_back(typed_row(16'h0002, 16'h0000, 24'h000000, 1'b1,
                                16'h0001, 16'hFFFF, 24'h000000));
    // same layer, position decides across the sign
    dir_tab.push_back(typed_row(16'h0003, 16'h0005, 24'h7FFFFF, 1'b0,
                                16'h0004, 16'h0005, 24'h800000));
    dir_tab.push_back(typed_row(16'h0004, 16'h0005, 24'h800000, 1'b1,
                                16'h0003, 16'h0005, 24'h7FFFFF));
    // equal keys stay put
    dir_tab.push_back(typed_row(16'h0005, 16'h0007, 24'h000010, 1'b0,
                                16'h0005, 16'h0007, 24'h000010));
    dir_tab.push_back(typed_row(16'h0006, 16'h0007, 24'h000010, 1'b1,
                                16'h0006, 16'h0007, 24'h000010));
    // reversed list: both passes
    for (int k = 0; k < 5; k++)
      dir_tab.push_back(word_row(16'(16'h0010 + k), 16'(4 - k), 24'h000000, k == 4));
    // already in order: no backward pass
    dir_tab.push_back(word_row(16'h0018, 16'h0001, 24'hFFFFFB, 1'b0));
    dir_tab.push_back(word_row(16'h0019, 16'h0001, 24'h000003, 1'b0));
    dir_tab.push_back(word_row(16'h001A, 16'h0002, 24'h000000, 1'b0));
    dir_tab.push_back(word_row(16'h001B, 16'h0003, 24'h000000, 1'b1));
    // pass-through; only bit 0 of the value counts, the spare index does nothing
    dir_tab.push_back(cfg_row(REG_RENDER_MODE, 32'hFFFF_FFFE));
    dir_tab.push_back(cfg_row(REG_SPARE, 32'h0000_0001));
    dir_tab.push_back(typed_row(16'h0020, 16'h0009, 24'h000000, 1'b0,
                                16'h0020, 16'h0009, 24'h000000));
    dir_tab.push_back(typed_row(16'h0021, 16'h0005, 24'h000000, 1'b0,
                                16'h0021, 16'h0005, 24'h000000));
    dir_tab.push_back(typed_row(16'h0022, 16'h0001, 24'h000000, 1'b1,
                                16'h0022, 16'h0001, 24'h000000));
    dir_tab.push_back(cfg_row(REG_RENDER_MODE, 32'h0000_0001));
    dir_tab.push_back(word_row(16'h0030, 16'h0000, 24'hFFFFFF, 1'b0));
    dir_tab.push_back(word_row(16'h0031, 16'h0000, 24'h800000, 1'b0));
    dir_tab.push_back(word_row(16'h0032, 16'h0000, 24'h000000, 1'b0));
    dir_tab.push_back(word_row(16'h0033, 16'hFFFF, 24'h800000, 1'b0));
    dir_tab.push_back(word_row(16'h0034, 16'h0000, 24'h7FFFFF, 1'b1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_tab[r].idx, dir_tab[r].data);
        cfg_check_mode();
      end else begin
        pace_sender();
        send_word(dir_tab[r].word, dir_tab[r].typed, dir_tab[r].want);
      end
    end

    // phases alternate the mode; three of them carry a full-store list
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        settle();
        data = $urandom;
        data[0] = (phase % 2 == 0);
        cfg_write(REG_RENDER_MODE, data);
        cfg_check_mode();
      end
      sent = 0;
      if (phase >= 2 && phase <= 4) begin
        // without last the store filling up ends the list
        send_list(LIST_MAX, phase != 2);
        sent = LIST_MAX;
      end
      while (sent < PHASE_WORDS) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        send_list(len, 1'b1);
        sent += len;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_words == 0) begin
      $display("** render_order_partial_sort_top: PASSED **");
    end else begin
      $display("** render_order_partial_sort_top: FAILED **");
    end
    $finish;
  end

endmodule
